// ===== rtl/idsp_pkg.sv =====
// shared types and constants of the 3x3 despike filter
package idsp_pkg;

	localparam int PIX_W      = 24;
	localparam int SUM_W      = 27;
	localparam int MULT_W     = 16;
	localparam int PROD_W     = SUM_W + MULT_W + 1;
	localparam int CTR_SHIFT  = 11;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_LINE_WIDTH  = 3'd0;
	localparam cfg_idx_t REG_LINE_COUNT  = 3'd1;
	localparam cfg_idx_t REG_LOW_LEVEL   = 3'd2;
	localparam cfg_idx_t REG_THRESH_MULT = 3'd3;
	localparam cfg_idx_t REG_MASK_ENABLE = 3'd4;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [12:0]       LINE_WIDTH_RST  = 13'd4096;
	localparam logic [15:0]       LINE_COUNT_RST  = 16'd512;
	localparam logic [PIX_W-1:0]  LOW_LEVEL_RST   = 24'd0;
	localparam logic [MULT_W-1:0] THRESH_MULT_RST = 16'd512;

	typedef logic signed [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic cmd;
		pix_t pixel_in;
		logic mask_bit;
	} in_item_t;

	typedef struct packed {
		pix_t pixel_out;
		logic replaced;
		logic last_in_row;
		logic last_of_image;
	} out_item_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} column_t;

	typedef struct packed {
		column_t left;
		column_t center;
		column_t right;
	} window_t;

endpackage

// ===== rtl/idsp_in_if.sv =====
// pixel input channel
interface idsp_in_if;
	import idsp_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/idsp_out_if.sv =====
// filtered pixel output channel
interface idsp_out_if;
	import idsp_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/idsp_ram.sv =====
// generic simple dual port ram with registered read
module idsp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/image_despike_3x3_unit.sv =====
// 3x3 spike removal filter: line stores, window, per-lane test and result queue
// a result passes through stage 1, stages 2..4 and the result queue after the item that completes
// its window is taken; the second of a last-column pair leaves the queue after the first
// throughput: one item per cycle, input held off while more than two results wait in the queue;
// a last-column item gives two results, a first-column one none
// reset clears counters, window, pipeline valids and the result queue; line stores are not cleared
module image_despike_3x3_unit #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  idsp_pkg::cfg_idx_t         cfg_idx,
	input  logic [idsp_pkg::CFG_W-1:0] cfg_wdata,
	idsp_in_if.sink                    pixels,
	idsp_out_if.source                 results
);
	import idsp_pkg::*;

	localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int MASK_DEPTH = 2 ** (CW + 1);
	localparam logic [CW:0] MAX_W = (CW + 1)'(MAX_WIDTH);

	function automatic logic signed [SUM_W-1:0] sum8(input window_t w);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'($signed(w.left.top)) + SUM_W'($signed(w.left.mid))
			+ SUM_W'($signed(w.left.bot)) + SUM_W'($signed(w.center.top))
			+ SUM_W'($signed(w.center.bot)) + SUM_W'($signed(w.right.top))
			+ SUM_W'($signed(w.right.mid)) + SUM_W'($signed(w.right.bot));
		return s;
	endfunction

	// configuration
	logic [12:0]       line_width_q;
	logic [15:0]       line_count_q;
	pix_t              low_level_q;
	logic [MULT_W-1:0] thresh_mult_q;
	logic              mask_enable_q;
	logic              geom_wr;

	assign geom_wr = cfg_wr_en && (cfg_idx == REG_LINE_WIDTH || cfg_idx == REG_LINE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q  <= LINE_WIDTH_RST;
			line_count_q  <= LINE_COUNT_RST;
			low_level_q   <= LOW_LEVEL_RST;
			thresh_mult_q <= THRESH_MULT_RST;
			mask_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_LINE_WIDTH:  line_width_q  <= cfg_wdata[12:0];
				REG_LINE_COUNT:  line_count_q  <= cfg_wdata[15:0];
				REG_LOW_LEVEL:   low_level_q   <= cfg_wdata[PIX_W-1:0];
				REG_THRESH_MULT: thresh_mult_q <= cfg_wdata[MULT_W-1:0];
				REG_MASK_ENABLE: mask_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [CW:0]   w_eff;
	logic [CW:0]   w_m1_full;
	logic [CW-1:0] w_m1;
	logic [15:0]   h_m1;

	always_comb begin
		if (line_width_q == 13'd0) begin
			w_eff = (CW + 1)'(1);
		end else if (line_width_q > MAX_W) begin
			w_eff = MAX_W;
		end else begin
			w_eff = (CW + 1)'(line_width_q);
		end
		w_m1_full = w_eff - (CW + 1)'(1);
		w_m1      = w_m1_full[CW-1:0];
		h_m1      = (line_count_q < 16'd2) ? 16'd1 : line_count_q - 16'd1;
	end

	// pipeline advance: the queue can always take two results
	logic [FIFO_AW:0] fifo_cnt_q;
	logic             adv;

	assign adv          = fifo_cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
	assign pixels.ready = adv;

	// stage 0: position counters and store reads
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic          draining_q;
	logic          in_fire;
	logic          is_pix;
	logic          launch;
	logic          pix_launch;
	logic          last_col0;

	assign in_fire    = pixels.valid && pixels.ready;
	assign is_pix     = pixels.data.cmd == CMD_PIXEL;
	assign launch     = in_fire && (is_pix ? !draining_q : draining_q);
	assign pix_launch = launch && is_pix;
	assign last_col0  = col_q == w_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (geom_wr) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (launch) begin
			if (last_col0) begin
				col_q <= '0;
				if (is_pix) begin
					if (row_q == h_m1) begin
						draining_q <= 1'b1;
						row_q      <= '0;
					end else begin
						row_q <= row_q + 16'd1;
					end
				end else begin
					draining_q <= 1'b0;
					row_q      <= '0;
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1 registers
	logic          v_s1;
	logic          pix_s1;
	pix_t          px_s1;
	logic [CW-1:0] col_s1;
	logic          first_s1;
	logic          last_s1;
	logic          sel_older_s1;
	logic          emit_s1;
	logic          lastimg_s1;
	logic          fwd_s1;
	pix_t          fwd_older_s1;
	pix_t          fwd_newer_s1;

	logic [PIX_W-1:0] older_rd;
	logic [PIX_W-1:0] newer_rd;
	logic [0:0]       mask_rd;
	pix_t             older_c;
	pix_t             newer_c;
	logic             wr_s1;

	assign wr_s1 = v_s1 && pix_s1 && adv;

	idsp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(col_s1),
		.wdata(newer_c),
		.re   (launch),
		.raddr(col_q),
		.rdata(older_rd)
	);

	idsp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(col_s1),
		.wdata(px_s1),
		.re   (launch),
		.raddr(col_q),
		.rdata(newer_rd)
	);

	// mask rows alternate by row parity; output row reads the other bank
	idsp_ram #(.WIDTH(1), .DEPTH(MASK_DEPTH)) u_mask_ram (
		.clk  (clk),
		.we   (pix_launch),
		.waddr({row_q[0], col_q}),
		.wdata(pixels.data.mask_bit),
		.re   (launch),
		.raddr({(is_pix ? ~row_q[0] : h_m1[0]), col_q}),
		.rdata(mask_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			v_s1   <= launch;
			fwd_s1 <= v_s1 && pix_s1 && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1       <= is_pix;
			px_s1        <= pixels.data.pixel_in;
			col_s1       <= col_q;
			first_s1     <= col_q == '0;
			last_s1      <= last_col0;
			sel_older_s1 <= !is_pix || (row_q >= 16'd2);
			emit_s1      <= !is_pix || (row_q != 16'd0);
			lastimg_s1   <= !is_pix;
			// write-back of the item ahead lands on the same edge as this read
			fwd_older_s1 <= newer_c;
			fwd_newer_s1 <= px_s1;
		end
	end

	// stage 1: new column and window shift
	window_t win_q;
	column_t ncol;
	window_t win_a;
	window_t win_b;
	window_t win_fill;
	window_t win_next;
	logic    mask_prev_q;

	always_comb begin
		newer_c  = fwd_s1 ? fwd_newer_s1 : $signed(newer_rd);
		older_c  = fwd_s1 ? fwd_older_s1 : $signed(older_rd);
		ncol.top = sel_older_s1 ? older_c : newer_c;
		ncol.mid = newer_c;
		ncol.bot = pix_s1 ? px_s1 : newer_c;
		win_fill = '{left: ncol, center: ncol, right: ncol};
		win_a    = '{left: win_q.center, center: win_q.right, right: ncol};
		if (first_s1) begin
			win_b = win_fill;
		end else begin
			win_b = '{left: win_q.right, center: ncol, right: ncol};
		end
		if (first_s1) begin
			win_next = win_fill;
		end else if (last_s1) begin
			win_next = win_b;
		end else begin
			win_next = win_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1 && adv) begin
			win_q <= win_next;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			mask_prev_q <= mask_rd[0];
		end
	end

	// stages 2..4: lane 0 is the column before, lane 1 the last column
	logic                     lv_s2 [2];
	window_t                  lw_s2 [2];
	logic                     lm_s2 [2];
	logic                     lastimg_s2;
	logic                     lv_s3 [2];
	logic signed [SUM_W-1:0]  sum_s3 [2];
	pix_t                     ctr_s3 [2];
	logic                     lm_s3 [2];
	logic                     lastimg_s3;
	logic                     lv_s4 [2];
	logic signed [PROD_W-1:0] prod_s4 [2];
	pix_t                     avg_s4 [2];
	pix_t                     ctr_s4 [2];
	logic                     allow_s4 [2];
	logic                     ge_low_s4 [2];
	logic                     lastimg_s4;
	out_item_t                res [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 2; l++) begin
				lv_s2[l] <= 1'b0;
				lv_s3[l] <= 1'b0;
				lv_s4[l] <= 1'b0;
			end
		end else if (adv) begin
			lv_s2[0] <= v_s1 && emit_s1 && !first_s1;
			lv_s2[1] <= v_s1 && emit_s1 && last_s1;
			for (int l = 0; l < 2; l++) begin
				lv_s3[l] <= lv_s2[l];
				lv_s4[l] <= lv_s3[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lw_s2[0]   <= win_a;
			lw_s2[1]   <= win_b;
			lm_s2[0]   <= mask_prev_q;
			lm_s2[1]   <= mask_rd[0];
			lastimg_s2 <= lastimg_s1;
			lastimg_s3 <= lastimg_s2;
			lastimg_s4 <= lastimg_s3;
			for (int l = 0; l < 2; l++) begin
				sum_s3[l]    <= sum8(lw_s2[l]);
				ctr_s3[l]    <= lw_s2[l].center.mid;
				lm_s3[l]     <= lm_s2[l];
				prod_s4[l]   <= sum_s3[l] * $signed({1'b0, thresh_mult_q});
				avg_s4[l]    <= sum_s3[l][SUM_W-1:3];
				ctr_s4[l]    <= ctr_s3[l];
				allow_s4[l]  <= !mask_enable_q || lm_s3[l];
				ge_low_s4[l] <= ctr_s3[l] >= low_level_q;
			end
		end
	end

	always_comb begin
		logic signed [PROD_W-1:0] lhs;
		logic                     rep;
		for (int l = 0; l < 2; l++) begin
			lhs = $signed({{(PROD_W - PIX_W - CTR_SHIFT){ctr_s4[l][PIX_W-1]}},
				ctr_s4[l], {CTR_SHIFT{1'b0}}});
			rep = allow_s4[l] && ge_low_s4[l] && (lhs > prod_s4[l]);
			res[l].pixel_out     = rep ? avg_s4[l] : ctr_s4[l];
			res[l].replaced      = rep;
			res[l].last_in_row   = l == 1;
			res[l].last_of_image = (l == 1) && lastimg_s4;
		end
	end

	// result queue
	out_item_t        fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW-1:0] wr_nx;
	logic               push_a;
	logic               push_b;
	logic               pop;
	logic [FIFO_AW:0]   n_push;

	assign push_a        = adv && lv_s4[0];
	assign push_b        = adv && lv_s4[1];
	assign pop           = results.valid && results.ready;
	assign wr_nx         = wr_q + FIFO_AW'(1);
	assign n_push        = (FIFO_AW + 1)'(push_a) + (FIFO_AW + 1)'(push_b);
	assign results.valid = fifo_cnt_q != '0;
	assign results.data  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_q[wr_q] <= res[0];
		end
		if (push_b) begin
			fifo_q[push_a ? wr_nx : wr_q] <= res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			fifo_cnt_q <= '0;
		end else begin
			wr_q       <= wr_q + n_push[FIFO_AW-1:0];
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + n_push - (FIFO_AW + 1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_m1)
		else $error("column counter beyond row width");

	a_drain_blocks_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_pix && draining_q) |=> !v_s1)
		else $error("pixel item entered pipeline while draining");

	a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (!results.data.last_of_image || results.data.last_in_row))
		else $error("image end flagged off a row end");
`endif

endmodule
